FILE: src/frs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_pkg
// Shared types, constants and digit extraction for the float32 radix sorter.
// ----------------------------------------------------------------------------
package frs_pkg;

  localparam int unsigned BUCKETS   = 256;
  localparam int unsigned DIGIT_W   = 8;
  localparam int unsigned BKT_W     = 9;  // bucket sweep counter, holds BUCKETS
  localparam logic [2:0]  PASS_EXP  = 3'd3;
  localparam logic [2:0]  PASS_SIGN = 3'd4;

  typedef struct packed {
    logic [31:0] value_bits;
    logic        last_item;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] sorted_bits;
    logic        last_sorted;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_CLEAR,
    ST_CNT_RD,
    ST_CNT_BKT,
    ST_CNT_WR,
    ST_PFX,
    ST_SCT_RD,
    ST_SCT_BKT,
    ST_SCT_WR,
    ST_NEG_RD,
    ST_NEG_ACC,
    ST_SGN_RD,
    ST_SGN_WR,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } frs_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_CNT_WR,
    OP_PFX,
    OP_SCT_WR,
    OP_NEG_RD,
    OP_NEG_ACC,
    OP_SGN_RD,
    OP_SGN_WR,
    OP_OUT_LD
  } frs_op_e;

  typedef struct packed {
    frs_op_e            op;
    logic [2:0]         pass;
    logic [BKT_W-1:0]   bkt;
    logic               first;
    logic               last;
  } frs_cmd_t;

  // fraction bytes, then exponent
  function automatic logic [DIGIT_W-1:0] frs_digit(input logic [31:0] v,
                                                   input logic [2:0]  pass);
    logic [DIGIT_W-1:0] d;
    case (pass)
      3'd0:    d = v[7:0];
      3'd1:    d = v[15:8];
      3'd2:    d = {1'b0, v[22:16]};
      default: d = v[30:23];
    endcase
    return d;
  endfunction

endpackage

FILE: src/float32_radix_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_radix_sorter
// Batch sorter for single-precision bit patterns, ascending float order.
// ----------------------------------------------------------------------------
// Input beats carry one 32-bit pattern each; last_item closes the batch, and a
// batch that reaches MAX_ITEMS closes by itself. in_ready_o is high only while
// collecting, one beat per cycle. The batch is then sorted by four stable
// 8-bit counting passes (fraction bytes, exponent) and a sign pass, and sent
// out in order with last_sorted on the final beat.
// The 256-entry bucket table is cleared and prefix-summed one entry per cycle
// in every counting pass, and each item of each counting pass takes a
// read/update of the bucket table. Results leave one at a time, each read from
// the buffer only after the previous one is accepted; a stall holds the current
// beat and the sequencer waits. No input is taken until the last result is
// accepted. Reset returns to collecting with an empty batch; the buffers and
// bucket table need no clearing after reset.
// ----------------------------------------------------------------------------
module float32_radix_sorter #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  frs_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output frs_pkg::out_beat_t  out_data_o
);

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  logic [AW-1:0]      load_addr;
  logic [AW-1:0]      idx;
  frs_pkg::frs_cmd_t  cmd;

  frs_ctrl #(.MAX_ITEMS(MAX_ITEMS), .AW(AW), .CW(CW)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_item),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .load_addr_o (load_addr),
    .idx_o       (idx),
    .cmd_o       (cmd)
  );

  frs_datapath #(.MAX_ITEMS(MAX_ITEMS), .AW(AW), .CW(CW)) u_datapath (
    .clk_i       (clk_i),
    .in_data_i   (in_data_i),
    .load_addr_i (load_addr),
    .idx_i       (idx),
    .cmd_i       (cmd),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output phases overlap");

  a_back_to_collect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_data_o.last_sorted) |=> in_ready_o)
    else $error("not collecting after final result beat");

  a_last_starts_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.last_item) |=> !in_ready_o)
    else $error("closing beat did not start the sort");
`endif

endmodule

FILE: src/frs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: src/frs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_ctrl
// Sequencer: collection, four counting passes, sign pass and result drain.
// ----------------------------------------------------------------------------
module frs_ctrl #(
  parameter int unsigned MAX_ITEMS = 64,
  parameter int unsigned AW        = 6,
  parameter int unsigned CW        = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [AW-1:0]    load_addr_o,
  output logic [AW-1:0]    idx_o,
  output frs_pkg::frs_cmd_t cmd_o
);

  frs_pkg::frs_state_e            state_q, state_d;
  logic [AW-1:0]                  load_q, load_d;
  logic [AW-1:0]                  idx_q, idx_d;
  logic [CW-1:0]                  n_q, n_d;
  logic [2:0]                     pass_q, pass_d;
  logic [frs_pkg::BKT_W-1:0]      bkt_q, bkt_d;
  logic                           idx_last;
  logic                           accept;

  assign idx_last = (CW'(idx_q) + CW'(1)) == n_q;
  assign accept   = in_valid_i && (state_q == frs_pkg::ST_COLLECT);

  always_comb begin
    state_d = state_q;
    load_d  = load_q;
    idx_d   = idx_q;
    n_d     = n_q;
    pass_d  = pass_q;
    bkt_d   = bkt_q;
    case (state_q)
      frs_pkg::ST_COLLECT: begin
        if (accept) begin
          if (in_last_i || load_q == AW'(MAX_ITEMS - 1)) begin
            n_d     = CW'(load_q) + CW'(1);
            load_d  = '0;
            pass_d  = '0;
            bkt_d   = '0;
            state_d = frs_pkg::ST_CLEAR;
          end else begin
            load_d = load_q + AW'(1);
          end
        end
      end
      frs_pkg::ST_CLEAR: begin
        bkt_d = bkt_q + frs_pkg::BKT_W'(1);
        if (bkt_q == frs_pkg::BKT_W'(frs_pkg::BUCKETS - 1)) begin
          idx_d   = '0;
          state_d = frs_pkg::ST_CNT_RD;
        end
      end
      frs_pkg::ST_CNT_RD:  state_d = frs_pkg::ST_CNT_BKT;
      frs_pkg::ST_CNT_BKT: state_d = frs_pkg::ST_CNT_WR;
      frs_pkg::ST_CNT_WR: begin
        if (idx_last) begin
          bkt_d   = '0;
          state_d = frs_pkg::ST_PFX;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = frs_pkg::ST_CNT_RD;
        end
      end
      frs_pkg::ST_PFX: begin
        if (bkt_q == frs_pkg::BKT_W'(frs_pkg::BUCKETS)) begin
          idx_d   = '0;
          state_d = frs_pkg::ST_SCT_RD;
        end else begin
          bkt_d = bkt_q + frs_pkg::BKT_W'(1);
        end
      end
      frs_pkg::ST_SCT_RD:  state_d = frs_pkg::ST_SCT_BKT;
      frs_pkg::ST_SCT_BKT: state_d = frs_pkg::ST_SCT_WR;
      frs_pkg::ST_SCT_WR: begin
        if (idx_last) begin
          idx_d = '0;
          if (pass_q == frs_pkg::PASS_EXP) begin
            pass_d  = frs_pkg::PASS_SIGN;
            state_d = frs_pkg::ST_NEG_RD;
          end else begin
            pass_d  = pass_q + 3'd1;
            bkt_d   = '0;
            state_d = frs_pkg::ST_CLEAR;
          end
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = frs_pkg::ST_SCT_RD;
        end
      end
      frs_pkg::ST_NEG_RD:  state_d = frs_pkg::ST_NEG_ACC;
      frs_pkg::ST_NEG_ACC: begin
        idx_d   = idx_last ? '0 : idx_q + AW'(1);
        state_d = idx_last ? frs_pkg::ST_SGN_RD : frs_pkg::ST_NEG_RD;
      end
      frs_pkg::ST_SGN_RD:  state_d = frs_pkg::ST_SGN_WR;
      frs_pkg::ST_SGN_WR: begin
        idx_d   = idx_last ? '0 : idx_q + AW'(1);
        state_d = idx_last ? frs_pkg::ST_OUT_RD : frs_pkg::ST_SGN_RD;
      end
      frs_pkg::ST_OUT_RD:  state_d = frs_pkg::ST_OUT_LD;
      frs_pkg::ST_OUT_LD:  state_d = frs_pkg::ST_OUT_WAIT;
      frs_pkg::ST_OUT_WAIT: begin
        if (out_ready_i) begin
          if (idx_last) begin
            state_d = frs_pkg::ST_COLLECT;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = frs_pkg::ST_OUT_RD;
          end
        end
      end
      default: state_d = frs_pkg::ST_COLLECT;
    endcase
  end

  always_comb begin
    cmd_o.op    = frs_pkg::OP_NONE;
    cmd_o.pass  = pass_q;
    cmd_o.bkt   = bkt_q;
    cmd_o.first = (idx_q == '0);
    cmd_o.last  = idx_last;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      frs_pkg::ST_COLLECT: begin
        in_ready_o = 1'b1;
        if (accept) begin
          cmd_o.op = frs_pkg::OP_LOAD;
        end
      end
      frs_pkg::ST_CLEAR:    cmd_o.op = frs_pkg::OP_CLEAR;
      frs_pkg::ST_CNT_WR:   cmd_o.op = frs_pkg::OP_CNT_WR;
      frs_pkg::ST_PFX:      cmd_o.op = frs_pkg::OP_PFX;
      frs_pkg::ST_SCT_WR:   cmd_o.op = frs_pkg::OP_SCT_WR;
      frs_pkg::ST_NEG_RD:   cmd_o.op = frs_pkg::OP_NEG_RD;
      frs_pkg::ST_NEG_ACC:  cmd_o.op = frs_pkg::OP_NEG_ACC;
      frs_pkg::ST_SGN_RD:   cmd_o.op = frs_pkg::OP_SGN_RD;
      frs_pkg::ST_SGN_WR:   cmd_o.op = frs_pkg::OP_SGN_WR;
      frs_pkg::ST_OUT_LD:   cmd_o.op = frs_pkg::OP_OUT_LD;
      frs_pkg::ST_OUT_WAIT: out_valid_o = 1'b1;
      default:              cmd_o.op = frs_pkg::OP_NONE;
    endcase
  end

  assign load_addr_o = load_q;
  assign idx_o       = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frs_pkg::ST_COLLECT;
      load_q  <= '0;
      idx_q   <= '0;
      n_q     <= '0;
      pass_q  <= '0;
      bkt_q   <= '0;
    end else begin
      state_q <= state_d;
      load_q  <= load_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      pass_q  <= pass_d;
      bkt_q   <= bkt_d;
    end
  end

endmodule

FILE: src/frs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_datapath
// Item and scratch buffers, bucket table, prefix sum and sign placement.
// ----------------------------------------------------------------------------
module frs_datapath #(
  parameter int unsigned MAX_ITEMS = 64,
  parameter int unsigned AW        = 6,
  parameter int unsigned CW        = 7
) (
  input  logic                  clk_i,
  input  frs_pkg::in_beat_t     in_data_i,
  input  logic [AW-1:0]         load_addr_i,
  input  logic [AW-1:0]         idx_i,
  input  frs_pkg::frs_cmd_t     cmd_i,
  output frs_pkg::out_beat_t    out_data_o
);

  logic [31:0]                  a_rdata, b_rdata, src_data;
  logic [CW-1:0]                cnt_rdata;
  logic                         src_b;
  logic [frs_pkg::DIGIT_W-1:0]  digit;
  logic [AW-1:0]                dst_addr, sgn_addr;

  logic                         a_we, b_we, c_we;
  logic [AW-1:0]                a_waddr, b_waddr;
  logic [31:0]                  a_wdata;
  logic [frs_pkg::DIGIT_W-1:0]  c_waddr, c_raddr;
  logic [CW-1:0]                c_wdata;

  logic [CW-1:0]                sum_q, sum_d;
  logic [CW-1:0]                neg_q, neg_d;
  logic [CW-1:0]                at_neg_q, at_neg_d;
  logic [CW-1:0]                at_pos_q, at_pos_d;
  frs_pkg::out_beat_t           out_q, out_d;

  // passes ping-pong between the two buffers; sign pass reads items, writes scratch
  assign src_b    = cmd_i.pass[0];
  assign src_data = src_b ? b_rdata : a_rdata;
  assign digit    = frs_pkg::frs_digit(src_data, cmd_i.pass);
  assign dst_addr = AW'(cnt_rdata);
  assign sgn_addr = src_data[31] ? AW'(neg_q - CW'(1) - at_neg_q) : AW'(at_pos_q);

  always_comb begin
    a_we    = 1'b0;
    a_waddr = dst_addr;
    a_wdata = src_data;
    b_we    = 1'b0;
    b_waddr = dst_addr;
    c_we    = 1'b0;
    c_waddr = digit;
    c_raddr = digit;
    c_wdata = cnt_rdata + CW'(1);
    case (cmd_i.op)
      frs_pkg::OP_LOAD: begin
        a_we    = 1'b1;
        a_waddr = load_addr_i;
        a_wdata = in_data_i.value_bits;
      end
      frs_pkg::OP_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = cmd_i.bkt[frs_pkg::DIGIT_W-1:0];
        c_wdata = '0;
      end
      frs_pkg::OP_CNT_WR: c_we = 1'b1;
      frs_pkg::OP_PFX: begin
        c_we    = (cmd_i.bkt != '0);
        c_waddr = frs_pkg::DIGIT_W'(cmd_i.bkt - frs_pkg::BKT_W'(1));
        c_raddr = cmd_i.bkt[frs_pkg::DIGIT_W-1:0];
        c_wdata = sum_q;
      end
      frs_pkg::OP_SCT_WR: begin
        c_we = 1'b1;
        a_we = src_b;
        b_we = !src_b;
      end
      frs_pkg::OP_SGN_WR: begin
        b_we    = 1'b1;
        b_waddr = sgn_addr;
      end
      default: c_we = 1'b0;
    endcase
  end

  always_comb begin
    sum_d    = sum_q;
    neg_d    = neg_q;
    at_neg_d = at_neg_q;
    at_pos_d = at_pos_q;
    out_d    = out_q;
    case (cmd_i.op)
      frs_pkg::OP_PFX:     sum_d = (cmd_i.bkt == '0) ? '0 : sum_q + cnt_rdata;
      frs_pkg::OP_NEG_RD: begin
        if (cmd_i.first) begin
          neg_d = '0;
        end
      end
      frs_pkg::OP_NEG_ACC: neg_d = neg_q + CW'(src_data[31]);
      frs_pkg::OP_SGN_RD: begin
        if (cmd_i.first) begin
          at_neg_d = '0;
          at_pos_d = neg_q;
        end
      end
      frs_pkg::OP_SGN_WR: begin
        if (src_data[31]) begin
          at_neg_d = at_neg_q + CW'(1);
        end else begin
          at_pos_d = at_pos_q + CW'(1);
        end
      end
      frs_pkg::OP_OUT_LD: begin
        out_d.sorted_bits = b_rdata;
        out_d.last_sorted = cmd_i.last;
      end
      default: sum_d = sum_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    sum_q    <= sum_d;
    neg_q    <= neg_d;
    at_neg_q <= at_neg_d;
    at_pos_q <= at_pos_d;
    out_q    <= out_d;
  end

  assign out_data_o = out_q;

  frs_ram #(.WIDTH(32), .DEPTH(MAX_ITEMS)) u_item_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .raddr_i (idx_i),
    .rdata_o (a_rdata)
  );

  frs_ram #(.WIDTH(32), .DEPTH(MAX_ITEMS)) u_scratch_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (src_data),
    .raddr_i (idx_i),
    .rdata_o (b_rdata)
  );

  frs_ram #(.WIDTH(CW), .DEPTH(frs_pkg::BUCKETS)) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (cnt_rdata)
  );

endmodule

FILE: bench/float32_radix_sorter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_radix_sorter_test
// Sends batches of float32 bit patterns to the sorter and predicts each sorted
// batch with its own radix passes. Every output beat is compared with the
// oldest predicted beat. Idle and stall rates vary by phase, and one long
// output hold fills the block.
// ----------------------------------------------------------------------------
module float32_radix_sorter_test;

  localparam int unsigned MAX_ITEMS   = 64;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned TAIL_CYCLES = 4000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  frs_pkg::in_beat_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  frs_pkg::out_beat_t out_data_o;

  float32_radix_sorter #(.MAX_ITEMS(MAX_ITEMS)) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  frs_pkg::out_beat_t pending_sorted [$];
  logic [31:0] batch_vals [MAX_ITEMS];
  logic [31:0] pass_buf [MAX_ITEMS];
  int unsigned batch_len      = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req_id    = 0;
  int unsigned hold_len       = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;
  logic [31:0] prev_pick      = 32'h3f80_0000;

  // stable counting pass on one digit of every stored value
  task automatic digit_pass(input int unsigned shift, input logic [31:0] mask);
    int unsigned tally [frs_pkg::BUCKETS];
    int unsigned run;
    int unsigned c;
    int unsigned slot;
    int unsigned k;
    logic [7:0]  d;
    for (k = 0; k < frs_pkg::BUCKETS; k++) tally[k] = 0;
    for (k = 0; k < batch_len; k++) begin
      d = 8'(((batch_vals[k] & mask) >> shift) & 32'hff);
      tally[d]++;
    end
    run = 0;
    for (k = 0; k < frs_pkg::BUCKETS; k++) begin
      c = tally[k];
      tally[k] = run;
      run += c;
    end
    for (k = 0; k < batch_len; k++) begin
      d = 8'(((batch_vals[k] & mask) >> shift) & 32'hff);
      slot = tally[d];
      tally[d]++;
      pass_buf[slot] = batch_vals[k];
    end
    for (k = 0; k < batch_len; k++) batch_vals[k] = pass_buf[k];
  endtask

  // negatives first, reversed; positives keep their order
  task automatic sign_split();
    int unsigned neg;
    int unsigned at_neg;
    int unsigned at_pos;
    int unsigned k;
    neg = 0;
    for (k = 0; k < batch_len; k++) neg += batch_vals[k][31];
    at_neg = 0;
    at_pos = neg;
    for (k = 0; k < batch_len; k++) begin
      if (batch_vals[k][31]) begin
        pass_buf[at_neg] = batch_vals[k];
        at_neg++;
      end else begin
        pass_buf[at_pos] = batch_vals[k];
        at_pos++;
      end
    end
    for (k = 0; k < batch_len; k++) begin
      batch_vals[k] = (k < neg) ? pass_buf[neg - 1 - k] : pass_buf[k];
    end
  endtask

  task automatic collect_value(input frs_pkg::in_beat_t beat);
    frs_pkg::out_beat_t e;
    int unsigned        k;
    batch_vals[batch_len] = beat.value_bits;
    batch_len++;
    if (beat.last_item || batch_len == MAX_ITEMS) begin
      digit_pass(0, 32'h007f_ffff);
      digit_pass(8, 32'h007f_ffff);
      digit_pass(16, 32'h007f_ffff);
      digit_pass(23, 32'hff << 23);
      sign_split();
      for (k = 0; k < batch_len; k++) begin
        e.sorted_bits = batch_vals[k];
        e.last_sorted = (k + 1 == batch_len);
        pending_sorted.push_back(e);
      end
      batch_len = 0;
    end
  endtask

  task automatic send_beat(input logic [31:0] v, input logic lst);
    frs_pkg::in_beat_t beat;
    beat.value_bits = v;
    beat.last_item  = lst;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    collect_value(beat);
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_sorted.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(5))
      0: v[30:23] = 8'hff;
      1: begin
        v[30:23] = 8'h00;
        if ($urandom_range(1)) v[22:0] = '0;
      end
      2: v[30:8] = {8'd127, 13'd0, 2'($urandom_range(3))};
      3: v = prev_pick;
      default: ;
    endcase
    prev_pick = v;
    return v;
  endfunction

  always @(posedge clk_i) begin
    if (hold_seen != hold_req_id) begin
      hold_seen = hold_req_id;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    frs_pkg::out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_sorted.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat, expected none, got %h/%b", $time,
                 out_data_o.sorted_bits, out_data_o.last_sorted);
      end else begin
        want = pending_sorted.pop_front();
        if (out_data_o.sorted_bits !== want.sorted_bits) begin
          mismatch_count++;
          $display("%0t: sorted_bits expected %h got %h", $time,
                   want.sorted_bits, out_data_o.sorted_bits);
        end
        if (out_data_o.last_sorted !== want.last_sorted) begin
          mismatch_count++;
          $display("%0t: last_sorted expected %b got %b", $time,
                   want.last_sorted, out_data_o.last_sorted);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_single_value();
    send_beat(32'h8000_0000, 1'b1);
  endtask

  // zeros of both signs, infinities, NaNs, denormals, extremes, a duplicate
  task automatic test_special_values();
    send_beat(32'h7fc0_0000, 1'b0);
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'h8000_0000, 1'b0);
    send_beat(32'hffff_ffff, 1'b0);
    send_beat(32'h7f80_0000, 1'b0);
    send_beat(32'hff80_0000, 1'b0);
    send_beat(32'h0000_0001, 1'b0);
    send_beat(32'h8000_0001, 1'b0);
    send_beat(32'h7f7f_ffff, 1'b0);
    send_beat(32'hff7f_ffff, 1'b0);
    send_beat(32'h3f80_0000, 1'b0);
    send_beat(32'hbf80_0000, 1'b0);
    send_beat(32'h3f80_0000, 1'b0);
    send_beat(32'h7fff_ffff, 1'b1);
  endtask

  // values that differ in one digit each
  task automatic test_digit_order();
    send_beat(32'h4000_0100, 1'b0);
    send_beat(32'h4000_0001, 1'b0);
    send_beat(32'h4001_0000, 1'b0);
    send_beat(32'h4080_0000, 1'b0);
    send_beat(32'h4000_0000, 1'b0);
    send_beat(32'h4000_0101, 1'b0);
    send_beat(32'hc000_0100, 1'b0);
    send_beat(32'hc000_0001, 1'b1);
  endtask

  // batch closes by itself at MAX_ITEMS
  task automatic test_full_batch();
    int unsigned k;
    for (k = 0; k < MAX_ITEMS; k++) send_beat(pick_value(), 1'b0);
  endtask

  // long output hold while two batches are offered
  task automatic test_backpressure();
    int unsigned k;
    hold_len    <= 6000;
    hold_req_id <= hold_req_id + 1;
    for (k = 0; k < 12; k++) send_beat(pick_value(), k == 11);
    for (k = 0; k < 8; k++) send_beat(pick_value(), k == 7);
  endtask

  task automatic test_random_batches(input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input int unsigned item_goal);
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    int unsigned k;
    logic        mark;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < item_goal) begin
      r = $urandom_range(99);
      if (r < 60) len = $urandom_range(8, 1);
      else if (r < 90) len = $urandom_range(24, 9);
      else len = $urandom_range(MAX_ITEMS, 25);
      mark = (len < MAX_ITEMS) || $urandom_range(1);
      for (k = 0; k < len; k++) send_beat(pick_value(), mark && (k + 1 == len));
      sent += len;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_single_value();
    test_special_values();
    test_digit_order();
    test_full_batch();
    test_backpressure();
    test_random_batches(0, 0, 60);
    test_random_batches(68, 0, 60);
    test_random_batches(0, 68, 60);
    test_random_batches(24, 24, 60);
    stop_sending();
    wait_drained();
    if (mismatch_count == 0 && pending_sorted.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
